// ===== rtl/core/rpi_pkg.sv =====
package rpi_pkg;

    // Fraction bits of the fixed-point format (Q16.16 by default)
    localparam int FRAC_BITS_DEF = 16;

    // Field widths
    localparam int CRD_W = 32;              // coordinates, t and positions
    localparam int DIR_W = 18;              // directions and normal components
    localparam int THR_W = 17;              // hit threshold
    localparam int NUM_W = 53;              // dot(P - O, N): three 51-bit products summed
    localparam int DEN_W = 38;              // dot(D, N): three 36-bit products summed
    localparam int Q_W   = 32;              // quotient bits, one per divider cell

    // Stream widths
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 128;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_PX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_PY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_PZ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NZ  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_THR   = 3'd6;

    // Register reset values
    localparam logic [CRD_W-1:0] RST_PLANE_P  = '0;
    localparam logic [DIR_W-1:0] RST_PLANE_NX = 18'd0;
    localparam logic [DIR_W-1:0] RST_PLANE_NY = 18'd65536;
    localparam logic [DIR_W-1:0] RST_PLANE_NZ = 18'd0;
    localparam logic [THR_W-1:0] RST_HIT_THR  = 17'd66;

    typedef logic [CRD_W-1:0] crd_t;
    typedef logic [DIR_W-1:0] dir_t;

    typedef struct packed {
        crd_t [2:0] o;
        dir_t [2:0] d;
    } ray_t;

    typedef struct packed {
        crd_t [2:0] p;
        dir_t [2:0] n;
    } plane_t;

    // Working word of the restoring divider
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] aden;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   quo;
    } div_t;

    // Per-ray sideband carried alongside the divider
    typedef struct packed {
        ray_t ray;
        logic neg;
        logic den_zero;
        logic ovf;
    } side_t;

    typedef struct packed {
        logic       hit;
        crd_t       t;
        crd_t [2:0] pos;
    } res_t;

endpackage

// ===== rtl/core/rpi_front.sv =====
module rpi_front
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  ray_t   in_ray,
    input  plane_t plane,
    output logic   out_valid,
    output div_t   out_div,
    output side_t  out_side
);

    localparam int SH    = Q_W - FRAC_BITS;
    localparam int CMP_W = (NUM_W > DEN_W + SH) ? NUM_W : DEN_W + SH;
    localparam int PN_W  = CRD_W + DIR_W + 1;
    localparam int DN_W  = 2 * DIR_W;

    logic [3:0] vld_reg;

    // stage 1: products
    logic signed [CRD_W:0]  diff    [3];
    logic signed [PN_W-1:0] pn_next [3];
    logic signed [DN_W-1:0] dn_next [3];
    logic signed [PN_W-1:0] pn_reg  [3];
    logic signed [DN_W-1:0] dn_reg  [3];
    ray_t                   ray1_reg;

    // stage 2: sums
    logic signed [NUM_W-1:0] num_next, num_reg;
    logic signed [DEN_W-1:0] den_next, den_reg;
    ray_t                    ray2_reg;

    // stage 3: magnitudes and signs
    logic [NUM_W-1:0] anum_next, anum_reg;
    logic [DEN_W-1:0] aden_next, aden_reg;
    logic             neg_reg, dz_reg;
    ray_t             ray3_reg;

    // stage 4: divider seed
    div_t  div_next, div_reg;
    side_t side_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i]    = (CRD_W+1)'($signed(plane.p[i])) - (CRD_W+1)'($signed(in_ray.o[i]));
            pn_next[i] = PN_W'(diff[i]) * PN_W'($signed(plane.n[i]));
            dn_next[i] = DN_W'($signed(in_ray.d[i])) * DN_W'($signed(plane.n[i]));
        end
    end

    assign num_next = NUM_W'(pn_reg[0]) + NUM_W'(pn_reg[1]) + NUM_W'(pn_reg[2]);
    assign den_next = DEN_W'(dn_reg[0]) + DEN_W'(dn_reg[1]) + DEN_W'(dn_reg[2]);

    assign anum_next = num_reg[NUM_W-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
    assign aden_next = den_reg[DEN_W-1] ? $unsigned(-den_reg) : $unsigned(den_reg);

    always_comb begin
        div_next.rem  = DEN_W'(anum_reg >> SH);
        div_next.aden = aden_reg;
        div_next.low  = Q_W'(anum_reg << FRAC_BITS);
        div_next.quo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pn_reg   <= pn_next;
            dn_reg   <= dn_next;
            ray1_reg <= in_ray;

            num_reg  <= num_next;
            den_reg  <= den_next;
            ray2_reg <= ray1_reg;

            anum_reg <= anum_next;
            aden_reg <= aden_next;
            neg_reg  <= num_reg[NUM_W-1] ^ den_reg[DEN_W-1];
            dz_reg   <= (den_reg == '0);
            ray3_reg <= ray2_reg;

            div_reg           <= div_next;
            side_reg.ray      <= ray3_reg;
            side_reg.neg      <= neg_reg;
            side_reg.den_zero <= dz_reg;
            // quotient of 2^32 or more: saturate
            side_reg.ovf      <= (CMP_W'(anum_reg) >= (CMP_W'(aden_reg) << SH));
        end
    end

    assign out_valid = vld_reg[3];
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/core/rpi_div_cell.sv =====
module rpi_div_cell
    import rpi_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  div_t  in_div,
    input  side_t in_side,
    output logic  out_valid,
    output div_t  out_div,
    output side_t out_side
);

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    div_t             div_next;
    logic             vld_reg;
    div_t             div_reg;
    side_t            side_reg;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        shifted       = {in_div.rem, in_div.low[Q_W-1]};
        trial         = {1'b0, shifted} - {2'b00, in_div.aden};
        div_next.aden = in_div.aden;
        div_next.low  = {in_div.low[Q_W-2:0], 1'b0};
        div_next.quo  = {in_div.quo[Q_W-2:0], ~trial[DEN_W+1]};
        if (!trial[DEN_W+1]) begin
            div_next.rem = trial[DEN_W-1:0];
        end else begin
            div_next.rem = shifted[DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg  <= div_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = vld_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/core/rpi_back.sv =====
module rpi_back
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [Q_W-1:0]   in_quo,
    input  side_t            in_side,
    input  logic [THR_W-1:0] thr,
    output logic             out_valid,
    output res_t             out_res
);

    localparam int PR_W  = CRD_W + DIR_W;
    localparam int SUM_W = PR_W + 1;

    localparam logic [CRD_W-1:0] T_MAX = {1'b0, {(CRD_W-1){1'b1}}};
    localparam logic [CRD_W-1:0] T_MIN = {1'b1, {(CRD_W-1){1'b0}}};

    logic [1:0] vld_reg;

    // stage 1: signed, saturated t and the hit decision
    logic [CRD_W-1:0] t_next, t1_reg;
    logic             big;
    logic             hit_next, hit1_reg;
    ray_t             ray1_reg;

    // stage 2: t * D
    logic signed [PR_W-1:0] prod_reg [3];
    logic [CRD_W-1:0]       t2_reg;
    logic                   hit2_reg;
    crd_t [2:0]             o2_reg;

    logic signed [SUM_W-1:0] shv [3];
    logic signed [SUM_W-1:0] sum [3];

    always_comb begin
        big = in_side.ovf | in_quo[Q_W-1];
        if (in_side.neg) begin
            t_next = big ? T_MIN : CRD_W'(-$signed(in_quo));
        end else begin
            t_next = big ? T_MAX : CRD_W'(in_quo);
        end
        hit_next = !in_side.den_zero && !t_next[CRD_W-1]
                   && (t_next[CRD_W-2:0] > (CRD_W-1)'(thr));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg   <= t_next;
            hit1_reg <= hit_next;
            ray1_reg <= in_side.ray;

            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= PR_W'($signed(t1_reg)) * PR_W'($signed(ray1_reg.d[i]));
            end
            t2_reg   <= t1_reg;
            hit2_reg <= hit1_reg;
            o2_reg   <= ray1_reg.o;
        end
    end

    // floor shift, add origin, saturate; zero everything on a miss
    always_comb begin
        out_res.hit = hit2_reg;
        out_res.t   = hit2_reg ? t2_reg : '0;
        for (int i = 0; i < 3; i++) begin
            shv[i] = SUM_W'(prod_reg[i]) >>> FRAC_BITS;
            sum[i] = shv[i] + SUM_W'($signed(o2_reg[i]));
            if (!hit2_reg) begin
                out_res.pos[i] = '0;
            end else if (sum[i][SUM_W-1:CRD_W-1] == '0
                         || sum[i][SUM_W-1:CRD_W-1] == '1) begin
                out_res.pos[i] = sum[i][CRD_W-1:0];
            end else begin
                out_res.pos[i] = sum[i][SUM_W-1] ? T_MIN : T_MAX;
            end
        end
    end

    assign out_valid = vld_reg[1];

endmodule

// ===== rtl/core/ray_plane_intersect_top.sv =====
// Ray / plane intersection, one ray per beat, fixed point with FRAC_BITS fraction bits.
// Throughput: one ray per clock when m_tready stays high.
// Pipeline: an accepted ray passes through 4 front stages, the divider chain of 32 cells
//   (one quotient bit each), 2 back stages and the output register, in that order; the
//   whole chain holds while the skid stage is full.
// Reset (aresetn low, synchronous): pipeline and output empty, plane registers back to
//   point (0,0,0), normal (0,1.0,0), threshold 66.
module ray_plane_intersect_top
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ray_ox[31:0], ray_oy[63:32], ray_oz[95:64], ray_dx[113:96], ray_dy[131:114],
    // ray_dz[149:132], zero pad [151:150]
    input  logic [S_TDATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // t_value[31:0], hit_x[63:32], hit_y[95:64], hit_z[127:96]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // hit[0]
    output logic                  m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Plane registers
    plane_t           plane_reg;
    logic [THR_W-1:0] thr_reg;

    // Pipeline advance: the whole chain moves unless the skid stage is holding a beat
    logic en;

    ray_t in_ray;

    // Cell chain links: index 0 is the front stage output, index Q_W the last cell
    logic  vld_chain  [Q_W+1];
    div_t  div_chain  [Q_W+1];
    side_t side_chain [Q_W+1];

    logic res_vld;
    res_t res;

    // Output register plus skid stage
    logic out_vld_reg, skid_vld_reg;
    res_t out_res_reg, skid_res_reg;

    // Configuration writes are always accepted and take effect on the accepting edge; unknown indexes drop.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg.p[0] <= RST_PLANE_P;
            plane_reg.p[1] <= RST_PLANE_P;
            plane_reg.p[2] <= RST_PLANE_P;
            plane_reg.n[0] <= RST_PLANE_NX;
            plane_reg.n[1] <= RST_PLANE_NY;
            plane_reg.n[2] <= RST_PLANE_NZ;
            thr_reg        <= RST_HIT_THR;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PLANE_PX: plane_reg.p[0] <= cfg_data;
                REG_PLANE_PY: plane_reg.p[1] <= cfg_data;
                REG_PLANE_PZ: plane_reg.p[2] <= cfg_data;
                REG_PLANE_NX: plane_reg.n[0] <= cfg_data[DIR_W-1:0];
                REG_PLANE_NY: plane_reg.n[1] <= cfg_data[DIR_W-1:0];
                REG_PLANE_NZ: plane_reg.n[2] <= cfg_data[DIR_W-1:0];
                REG_HIT_THR:  thr_reg        <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the input beat
    assign in_ray.o[0] = s_tdata[31:0];
    assign in_ray.o[1] = s_tdata[63:32];
    assign in_ray.o[2] = s_tdata[95:64];
    assign in_ray.d[0] = s_tdata[113:96];
    assign in_ray.d[1] = s_tdata[131:114];
    assign in_ray.d[2] = s_tdata[149:132];

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // Front: dot products, magnitudes, divider seed and overflow check
    rpi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_ray    (in_ray),
        .plane     (plane_reg),
        .out_valid (vld_chain[0]),
        .out_div   (div_chain[0]),
        .out_side  (side_chain[0])
    );

    // Divider: each cell resolves one quotient bit, MSB first, and hands on
    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        rpi_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld_chain[g]),
            .in_div    (div_chain[g]),
            .in_side   (side_chain[g]),
            .out_valid (vld_chain[g+1]),
            .out_div   (div_chain[g+1]),
            .out_side  (side_chain[g+1])
        );
    end

    // Back: sign and saturate t, hit test, position
    rpi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_chain[Q_W]),
        .in_quo    (div_chain[Q_W].quo),
        .in_side   (side_chain[Q_W]),
        .thr       (thr_reg),
        .out_valid (res_vld),
        .out_res   (res)
    );

    // Output register with skid: a finished beat waits here while the chain keeps
    // moving; the skid catches the one beat that arrives while the output stalls,
    // and the chain holds only while the skid is full.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (res_vld) begin
            if (!out_vld_reg || m_tready) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_tready) begin
                out_res_reg <= skid_res_reg;
            end
        end else if (res_vld) begin
            if (!out_vld_reg || m_tready) begin
                out_res_reg <= res;
            end else begin
                skid_res_reg <= res;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_res_reg.pos[2], out_res_reg.pos[1], out_res_reg.pos[0],
                       out_res_reg.t};
    assign m_tuser  = out_res_reg.hit;

endmodule

// ===== dv/ray_plane_intersect_top_tb.sv =====
`timescale 1ns / 100ps

module ray_plane_intersect_top_tb;
    import rpi_pkg::*;

    localparam int      FRAC         = FRAC_BITS_DEF;
    localparam int      ONE          = 1 << FRAC;           // 1.0 in Q16.16
    localparam longint  CRD_MAX      = 64'sd2147483647;
    localparam longint  CRD_MIN      = -64'sd2147483648;
    localparam int      RAYS_PER_SET = 84;                  // rays between plane reloads
    localparam int      TAIL_CYCLES  = 60;                  // pipeline latency plus margin
    localparam int      LIMIT_CYCLES = 400000;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the plane registers, updated on each accepted write beat
    crd_t              plane_p [3];
    dir_t              plane_n [3];
    logic [THR_W-1:0]  hit_thr;

    res_t pending_hits [$];     // predicted results, oldest first
    int   mismatch_cnt = 0;
    int   cycle_cnt    = 0;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;

    ray_plane_intersect_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("ray_plane_intersect_top test failed");
            $finish;
        end
    end

    // Receiver back-pressure: drop m_tready at random per the current idle rate
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic longint sat_crd(longint v);
        if (v > CRD_MAX) return CRD_MAX;
        if (v < CRD_MIN) return CRD_MIN;
        return v;
    endfunction

    // Intersect one ray with the plane held in the shadow registers.
    // Dot products are exact; t is a truncated magnitude quotient with the sign
    // reapplied, then clamped. Positions use a floor shift of t*D.
    function automatic res_t intersect_ray(ray_t r);
        longint num, den, anum, aden, quo, rem, mag, t;
        bit     neg;
        res_t   res;
        num = 0;
        den = 0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            num += (longint'($signed(plane_p[i])) - longint'($signed(r.o[i])))
                   * longint'($signed(plane_n[i]));
            den += longint'($signed(r.d[i])) * longint'($signed(plane_n[i]));
        end
        // Ray parallel to the plane: no hit
        if (den == 0) return res;
        neg  = (num < 0) != (den < 0);
        anum = (num < 0) ? -num : num;
        aden = (den < 0) ? -den : den;
        quo  = anum / aden;
        rem  = anum % aden;
        if (quo >= (longint'(1) << (CRD_W - FRAC)))
            mag = longint'(1) << CRD_W;
        else
            mag = (quo << FRAC) + ((rem << FRAC) / aden);
        t = sat_crd(neg ? -mag : mag);
        if (t <= longint'(hit_thr)) return res;
        res.hit = 1'b1;
        res.t   = crd_t'(t);
        for (int i = 0; i < 3; i++) begin
            res.pos[i] = crd_t'(sat_crd(longint'($signed(r.o[i]))
                         + ((t * longint'($signed(r.d[i]))) >>> FRAC)));
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit    = m_tuser;
            got.t      = m_tdata[31:0];
            got.pos[0] = m_tdata[63:32];
            got.pos[1] = m_tdata[95:64];
            got.pos[2] = m_tdata[127:96];
            if (pending_hits.size() == 0) begin
                note_mismatch("unexpected result", 32'h0, got.t);
            end else begin
                want = pending_hits.pop_front();
                if (got.hit !== want.hit)
                    note_mismatch("hit", 32'(want.hit), 32'(got.hit));
                if (got.t !== want.t)
                    note_mismatch("t_value", want.t, got.t);
                if (got.pos[0] !== want.pos[0])
                    note_mismatch("hit_x", want.pos[0], got.pos[0]);
                if (got.pos[1] !== want.pos[1])
                    note_mismatch("hit_y", want.pos[1], got.pos[1]);
                if (got.pos[2] !== want.pos[2])
                    note_mismatch("hit_z", want.pos[2], got.pos[2]);
            end
        end
    end

    // Present one ray, with random gaps ahead of it, and hold until accepted.
    // Valid stays high on return so back-to-back rays need no extra edge.
    task automatic send_ray(input ray_t r);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r.d[2], r.d[1], r.d[0], r.o[2], r.o[1], r.o[0]};
        do @(posedge aclk); while (!s_tready);
        pending_hits.push_back(intersect_ray(r));
    endtask

    // Drop valid and let every outstanding result drain
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PLANE_PX: plane_p[0] = data;
            REG_PLANE_PY: plane_p[1] = data;
            REG_PLANE_PZ: plane_p[2] = data;
            REG_PLANE_NX: plane_n[0] = data[DIR_W-1:0];
            REG_PLANE_NY: plane_n[1] = data[DIR_W-1:0];
            REG_PLANE_NZ: plane_n[2] = data[DIR_W-1:0];
            REG_HIT_THR:  hit_thr    = data[THR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Fill bits above a register's width with junk half the time
    function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
        logic [31:0] mask;
        logic [31:0] junk;
        mask = (32'h1 << w) - 32'h1;
        junk = $urandom;
        if ($urandom_range(0, 1)) return v & mask;
        return (v & mask) | (junk & ~mask);
    endfunction

    function automatic ray_t make_ray(input longint ox, oy, oz, dx, dy, dz);
        ray_t r;
        r.o[0] = crd_t'(ox);
        r.o[1] = crd_t'(oy);
        r.o[2] = crd_t'(oz);
        r.d[0] = dir_t'(dx);
        r.d[1] = dir_t'(dy);
        r.d[2] = dir_t'(dz);
        return r;
    endfunction

    function automatic crd_t rand_coord();
        int v;
        case ($urandom_range(0, 4))
            0: return crd_t'($urandom);
            1: begin
                case ($urandom_range(0, 2))
                    0: return crd_t'(CRD_MAX);
                    1: return crd_t'(CRD_MIN);
                    default: return '0;
                endcase
            end
            2: v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            default: v = int'($urandom_range(0, 1 << 27)) - (1 << 26);
        endcase
        return crd_t'(v);
    endfunction

    function automatic dir_t rand_dir();
        int v;
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 2)) * ONE - ONE;
            1: v = int'($urandom_range(0, 512)) - 256;
            default: v = int'($urandom_range(0, 2 * ONE)) - ONE;
        endcase
        return dir_t'(v);
    endfunction

    // Mostly rays starting near the plane point so t lands in range,
    // the rest anywhere in the coordinate space
    function automatic ray_t rand_ray();
        ray_t r;
        bit   near;
        near = ($urandom_range(0, 99) < 60);
        for (int i = 0; i < 3; i++) begin
            r.d[i] = rand_dir();
            if (near)
                r.o[i] = plane_p[i] + crd_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
            else
                r.o[i] = rand_coord();
        end
        return r;
    endfunction

    task automatic load_random_plane();
        dir_t        n [3];
        int          axis;
        logic [31:0] thr;
        axis = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            if (axis == 0)
                n[i] = '0;                  // degenerate normal: every ray parallel
            else if (axis <= 4)
                n[i] = (i == axis % 3) ? dir_t'($urandom_range(0, 1) ? ONE : -ONE) : '0;
            else
                n[i] = rand_dir();
        end
        case ($urandom_range(0, 3))
            0: thr = 32'd0;
            1: thr = 32'(ONE);
            2: thr = 32'(RST_HIT_THR);
            default: thr = $urandom_range(0, ONE);
        endcase
        write_reg(REG_PLANE_PX, rand_coord());
        write_reg(REG_PLANE_PY, rand_coord());
        write_reg(REG_PLANE_PZ, rand_coord());
        write_reg(REG_PLANE_NX, with_junk(32'(n[0]), DIR_W));
        write_reg(REG_PLANE_NY, with_junk(32'(n[1]), DIR_W));
        write_reg(REG_PLANE_NZ, with_junk(32'(n[2]), DIR_W));
        write_reg(REG_HIT_THR, with_junk(thr, THR_W));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, $urandom);
    endtask

    // Plane left at reset: y = 0, normal +y, threshold 66
    task automatic test_reset_plane();
        send_ray(make_ray(0, -10 * ONE, 0, 0, ONE, 0));            // straight hit at t = 10
        send_ray(make_ray(0, 10 * ONE, 0, 0, ONE, 0));             // plane behind the ray
        send_ray(make_ray(0, 10 * ONE, 0, 0, -ONE, 0));            // both dots negative
        send_ray(make_ray(3 * ONE, -5 * ONE, 7 * ONE, ONE, 0, 0)); // parallel
        send_ray(make_ray(0, -66, 0, 0, ONE, 0));                  // t equals threshold
        send_ray(make_ray(0, -67, 0, 0, ONE, 0));                  // one step past threshold
        send_ray(make_ray(CRD_MAX, CRD_MIN, CRD_MIN, ONE, 1, -ONE)); // t and position clamp
        send_ray(make_ray(CRD_MIN, CRD_MAX, CRD_MAX, -ONE, -ONE, ONE));
        send_ray(make_ray(0, 0, 0, 0, 0, 0));                      // all zero
    endtask

    // Plane registers at their extremes, then an unused index
    task automatic test_plane_extremes();
        wait_drained();
        write_reg(REG_PLANE_PX, 32'(CRD_MAX));
        write_reg(REG_PLANE_PY, 32'(CRD_MIN));
        write_reg(REG_PLANE_PZ, 32'd0);
        write_reg(REG_PLANE_NX, 32'hFFFF_0000 | 32'(dir_t'(-ONE)));
        write_reg(REG_PLANE_NY, 32'(ONE));
        write_reg(REG_PLANE_NZ, 32'd0);
        write_reg(REG_HIT_THR, 32'd0);
        send_ray(make_ray(0, 0, 0, ONE, ONE, 0));                  // dot(D, N) cancels to zero
        send_ray(make_ray(0, 0, 0, ONE, -ONE, 0));                 // huge positive t
        send_ray(make_ray(0, 0, 0, -ONE, ONE, 0));                 // huge negative t
        send_ray(make_ray(CRD_MAX, CRD_MIN, 0, ONE, 0, 0));        // origin on plane, t = 0
        wait_drained();
        write_reg(REG_HIT_THR, with_junk(32'(ONE), THR_W));
        write_reg(REG_PLANE_NY, 32'd0);
        write_reg(REG_PLANE_NZ, 32'(dir_t'(-ONE)));
        send_ray(make_ray(CRD_MAX, CRD_MIN, ONE, 0, 0, -ONE));     // t = 1.0, not past thr of 1.0
        send_ray(make_ray(CRD_MAX, CRD_MIN, ONE + 1, 0, 0, -ONE)); // t just past thr of 1.0
        send_ray(make_ray(CRD_MAX, CRD_MIN, CRD_MAX, -ONE, ONE, -ONE));
        wait_drained();
        write_reg(REG_UNUSED, $urandom);
        send_ray(make_ray(CRD_MAX, CRD_MIN, ONE + 1, 0, 0, -ONE));
    endtask

    // Random planes and rays across the three idle profiles
    task automatic test_random_rays();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 53;
                end
                1: begin
                    tx_idle_pct = 53;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int set = 0; set < 4; set++) begin
                wait_drained();
                load_random_plane();
                repeat (RAYS_PER_SET) send_ray(rand_ray());
            end
        end
    endtask

    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        plane_p[0] = RST_PLANE_P;
        plane_p[1] = RST_PLANE_P;
        plane_p[2] = RST_PLANE_P;
        plane_n[0] = RST_PLANE_NX;
        plane_n[1] = RST_PLANE_NY;
        plane_n[2] = RST_PLANE_NZ;
        hit_thr    = RST_HIT_THR;
        tx_idle_pct = 20;
        rx_idle_pct = 53;

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_plane();
        test_plane_extremes();
        test_random_rays();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && pending_hits.size() == 0) begin
            $display("ray_plane_intersect_top test passed");
        end else begin
            $display("ray_plane_intersect_top test failed");
        end
        $finish;
    end

endmodule
